### rtl/core/lusd_pkg.sv
// types, constants and decode helpers shared by the lenient utf-8 stream decoder
`default_nettype none
package lusd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CP_BITS    = 21;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [2:0] LEAD2_PAT   = 3'h6;
  localparam logic [3:0] LEAD3_PAT   = 4'he;
  localparam logic [4:0] LEAD4_PAT   = 5'h1e;
  localparam logic [7:0] LEAD2_MASK  = 8'h1f;
  localparam logic [7:0] LEAD3_MASK  = 8'h0f;
  localparam logic [7:0] LEAD4_MASK  = 8'h07;
  localparam logic [7:0] CONT_MASK   = 8'h3f;

  localparam logic [COUNT_BITS-1:0] CAP_RESET = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_word_t;

  typedef struct packed {
    logic [CP_BITS-1:0]    code_point;
    logic [2:0]            bytes_used;
    logic                  point_valid;
    logic                  end_of_stream;
    logic [COUNT_BITS-1:0] total_emitted;
  } out_word_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b < ASCII_LIMIT) begin
      len = 3'd1;
    end else if (b[7:5] == LEAD2_PAT) begin
      len = 3'd2;
    end else if (b[7:4] == LEAD3_PAT) begin
      len = 3'd3;
    end else if (b[7:3] == LEAD4_PAT) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [CP_BITS-1:0] assemble2(input logic [7:0] b0, input logic [7:0] b1);
    logic [7:0] m0;
    logic [7:0] m1;
    m0 = b0 & LEAD2_MASK;
    m1 = b1 & CONT_MASK;
    return {10'd0, m0[4:0], m1[5:0]};
  endfunction

  function automatic logic [CP_BITS-1:0] assemble3(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2);
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    m0 = b0 & LEAD3_MASK;
    m1 = b1 & CONT_MASK;
    m2 = b2 & CONT_MASK;
    return {5'd0, m0[3:0], m1[5:0], m2[5:0]};
  endfunction

  function automatic logic [CP_BITS-1:0] assemble4(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] m3;
    m0 = b0 & LEAD4_MASK;
    m1 = b1 & CONT_MASK;
    m2 = b2 & CONT_MASK;
    m3 = b3 & CONT_MASK;
    return {m0[2:0], m1[5:0], m2[5:0], m3[5:0]};
  endfunction

endpackage
`default_nettype wire

### rtl/core/lenient_utf8_stream_decoder.sv
// top level of the lenient utf-8 stream decoder
// Takes one byte word per cycle, unless stalled, into an input register, decodes it in one
// pass against the open-sequence state and loads its results (zero to three words) into a
// three-entry result buffer that drains one word per cycle on dst while dst_stall is low. A
// byte yielding at most one word keeps the rate at one byte per cycle if dst is not stalled;
// one yielding more words holds the input until the single output port has drained the buffer
// to its last word. Writes on cfg set the per-stream cap on code points, taken at any time.
`default_nettype none
module lenient_utf8_stream_decoder (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 src_valid,
  output logic                                src_stall,
  input  lusd_pkg::in_word_t                  src_data,
  output logic                                dst_valid,
  input  wire                                 dst_stall,
  output lusd_pkg::out_word_t                 dst_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [lusd_pkg::COUNT_BITS-1:0]     cfg_data
);

  lusd_pkg::in_word_t              in_q;
  logic                            in_q_valid;
  logic [7:0]                      held [3];
  logic [1:0]                      held_count;
  logic [2:0]                      seq_len;
  logic [lusd_pkg::COUNT_BITS-1:0] count;
  logic [lusd_pkg::COUNT_BITS-1:0] max_cp;
  lusd_pkg::out_word_t             res [3];
  logic [1:0]                      res_cnt;

  logic [7:0]                      held_next [3];
  logic [1:0]                      held_count_next;
  logic [2:0]                      seq_len_next;
  logic [lusd_pkg::COUNT_BITS-1:0] count_next;
  lusd_pkg::out_word_t             res_next [3];
  logic [1:0]                      res_cnt_next;

  logic [7:0]                      b;
  logic                            last;
  logic [2:0]                      lead;
  logic [2:0]                      held1_len;
  logic [lusd_pkg::CP_BITS-1:0]    cand_cp [3];
  logic [2:0]                      cand_used [3];
  logic [1:0]                      ncand;
  logic [lusd_pkg::COUNT_BITS-1:0] room;
  logic [2:0]                      emit_ok;
  logic [1:0]                      nres;
  logic                            dst_take;
  logic                            proc;

  assign b         = in_q.in_byte;
  assign last      = in_q.stream_last;
  assign lead      = lusd_pkg::lead_len(b);
  assign held1_len = lusd_pkg::lead_len(held[1]);

  assign dst_valid = (res_cnt != 2'd0);
  assign dst_data  = res[0];
  assign dst_take  = dst_valid && !dst_stall;
  assign proc      = in_q_valid && ((res_cnt == 2'd0) || ((res_cnt == 2'd1) && dst_take));
  assign src_stall = in_q_valid && !proc;
  assign cfg_ready = 1'b1;

  // candidate code points and sequence tracking
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cand_cp[j]   = '0;
      cand_used[j] = 3'd0;
      held_next[j] = held[j];
    end
    ncand           = 2'd0;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    priority if (seq_len == 3'd0) begin
      if (lead == 3'd1 || last) begin
        cand_cp[0]   = {13'd0, b};
        cand_used[0] = 3'd1;
        ncand        = 2'd1;
      end else begin
        held_next[0]    = b;
        held_count_next = 2'd1;
        seq_len_next    = lead;
      end
    end else if (({1'b0, held_count} + 3'd1) >= seq_len) begin
      unique case (seq_len)
        3'd2: cand_cp[0] = lusd_pkg::assemble2(held[0], b);
        3'd3: cand_cp[0] = lusd_pkg::assemble3(held[0], held[1], b);
        default: cand_cp[0] = lusd_pkg::assemble4(held[0], held[1], held[2], b);
      endcase
      cand_used[0]    = seq_len;
      ncand           = 2'd1;
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end else if (!last) begin
      held_next[held_count] = b;
      held_count_next       = held_count + 2'd1;
    end else begin
      cand_cp[0]   = {13'd0, held[0]};
      cand_used[0] = 3'd1;
      if (held_count == 2'd1) begin
        cand_cp[1]   = {13'd0, b};
        cand_used[1] = 3'd1;
        ncand        = 2'd2;
      end else if (held1_len == 3'd2) begin
        cand_cp[1]   = lusd_pkg::assemble2(held[1], b);
        cand_used[1] = 3'd2;
        ncand        = 2'd2;
      end else begin
        cand_cp[1]   = {13'd0, held[1]};
        cand_used[1] = 3'd1;
        cand_cp[2]   = {13'd0, b};
        cand_used[2] = 3'd1;
        ncand        = 2'd3;
      end
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end
    if (last) begin
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end
  end

  // cap, end mark and result words
  always_comb begin
    room = (max_cp > count) ? (max_cp - count) : '0;
    for (int j = 0; j < 3; j++) begin
      emit_ok[j] = (ncand > 2'(j)) && (room > lusd_pkg::COUNT_BITS'(j));
    end
    priority if (emit_ok[2]) begin
      nres = 2'd3;
    end else if (emit_ok[1]) begin
      nres = 2'd2;
    end else if (emit_ok[0]) begin
      nres = 2'd1;
    end else begin
      nres = 2'd0;
    end
    for (int j = 0; j < 3; j++) begin
      res_next[j].code_point    = cand_cp[j];
      res_next[j].bytes_used    = cand_used[j];
      res_next[j].point_valid   = 1'b1;
      res_next[j].end_of_stream = last && (nres == 2'(j + 1));
      res_next[j].total_emitted = count + lusd_pkg::COUNT_BITS'(j + 1);
    end
    res_cnt_next = nres;
    if (last && nres == 2'd0) begin
      res_next[0].code_point    = '0;
      res_next[0].bytes_used    = 3'd0;
      res_next[0].point_valid   = 1'b0;
      res_next[0].end_of_stream = 1'b1;
      res_next[0].total_emitted = count;
      res_cnt_next              = 2'd1;
    end
    count_next = last ? '0 : (count + lusd_pkg::COUNT_BITS'(nres));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      held_count <= 2'd0;
      seq_len    <= 3'd0;
      count      <= '0;
      max_cp     <= lusd_pkg::CAP_RESET;
      res_cnt    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_cp <= cfg_data;
      end
      if (src_valid && !src_stall) begin
        in_q_valid <= 1'b1;
      end else if (proc) begin
        in_q_valid <= 1'b0;
      end
      if (proc) begin
        held_count <= held_count_next;
        seq_len    <= seq_len_next;
        count      <= count_next;
        res_cnt    <= res_cnt_next;
      end else if (dst_take) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      in_q <= src_data;
    end
    if (proc) begin
      for (int j = 0; j < 3; j++) begin
        held[j] <= held_next[j];
        res[j]  <= res_next[j];
      end
    end else if (dst_take) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule
`default_nettype wire

### rtl/core/lusd_checker.sv
// port-level checks for the lenient utf-8 stream decoder, bound to the top level
`default_nettype none
module lusd_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 dst_valid,
  input wire                 dst_stall,
  input lusd_pkg::out_word_t dst_data
);

  // stalled word holds
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("dst word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("dst word shown right after reset");

  // empty word is only the end mark
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_data.point_valid |->
      dst_data.end_of_stream && dst_data.bytes_used == 3'd0 && dst_data.code_point == '0)
    else $error("empty word without end mark");

  a_point_shape: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.point_valid |->
      dst_data.bytes_used != 3'd0 && dst_data.bytes_used <= 3'd4 &&
      dst_data.total_emitted != '0 &&
      (dst_data.bytes_used != 3'd1 || dst_data.code_point[20:8] == '0))
    else $error("malformed code point word");

endmodule

bind lenient_utf8_stream_decoder lusd_checker u_lusd_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);
`default_nettype wire
